// ===== design/fsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_pkg
// shared types and constants of the feeder sequencer: op codes, pulse
// widths, status codes and register indexes
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int PULSE_W = 11;
    localparam int CNT_W   = 16;
    localparam int CFG_W   = 16;

    typedef logic [PULSE_W-1:0] pulse_t;
    typedef logic [CNT_W-1:0]   count_t;

    localparam pulse_t PULSE_MID  = 11'd1500;
    localparam pulse_t PULSE_LOW  = 11'd1000;
    localparam pulse_t PULSE_HIGH = 11'd2000;
    localparam pulse_t PULSE_STEP = 11'd100;
    localparam count_t CNT_MAX    = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_FLY_ON    = 3'd1,
        OP_FLY_OFF   = 3'd2,
        OP_FEED_ON   = 3'd3,
        OP_FEED_OFF  = 3'd4,
        OP_FEED_REV  = 3'd5,
        OP_AUTO_FEED = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        FEED_STAT_OFF   = 2'd0,
        FEED_STAT_FULL  = 2'd1,
        FEED_STAT_OTHER = 2'd2
    } feed_stat_t;

    typedef enum logic {
        CFG_MAX_SHOOT = 1'b0,
        CFG_SPIN_DOWN = 1'b1
    } cfg_idx_t;

endpackage

`default_nettype wire

// ===== design/fsc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_if
// valid/ready channels of the feeder sequencer: command channel and
// result channel
// ----------------------------------------------------------------------------
interface fsc_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic       ir_level;

    modport source (output valid, output op, output ir_level, input ready);
    modport sink   (input valid, input op, input ir_level, output ready);
endinterface

interface fsc_res_if;
    logic        valid;
    logic        ready;
    logic [10:0] flywheel_pulse_us;
    logic [10:0] feeder_pulse_us;
    logic [1:0]  feeder_status;
    logic        auto_feeding;

    modport source (output valid, output flywheel_pulse_us, output feeder_pulse_us,
                    output feeder_status, output auto_feeding, input ready);
    modport sink   (input valid, input flywheel_pulse_us, input feeder_pulse_us,
                    input feeder_status, input auto_feeding, output ready);
endinterface

`default_nettype wire

// ===== design/fsc_ramp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_ramp
// one ramp step of a servo pulse toward its goal, snapping to neutral
// ----------------------------------------------------------------------------
module fsc_ramp
    import fsc_pkg::*;
(
    input  wire pulse_t now,
    input  wire pulse_t goal,
    output pulse_t      next
);

    logic [PULSE_W:0] now_up;
    logic [PULSE_W:0] goal_up;

    assign now_up  = {1'b0, now} + {1'b0, PULSE_STEP};
    assign goal_up = {1'b0, goal} + {1'b0, PULSE_STEP};

    always_comb
    begin
        if (now == goal)
        begin
            next = now;
        end
        else if (goal == PULSE_MID)
        begin
            next = PULSE_MID;
        end
        else if (goal < PULSE_MID)
        begin
            next = ({1'b0, now} >= goal_up) ? (now - PULSE_STEP) : goal;
        end
        else
        begin
            next = (now_up <= {1'b0, goal}) ? now_up[PULSE_W-1:0] : goal;
        end
    end

endmodule

`default_nettype wire

// ===== design/feeder_sequencer_with_ramped_drives.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// feeder_sequencer_with_ramped_drives
// flywheel and feeder servo sequencer with ramped drives and auto-feed
// ----------------------------------------------------------------------------
// usage:
//   cmd channel carries one op per transaction (tick with ir level, drive
//   commands, auto feed); res channel returns one transaction per command
//   with both pulse widths, feeder status and the auto-feed flag after it
//   cfg_we/cfg_index/cfg_data write max_shoot_ticks (0) and
//   spin_down_ticks (1); write only while no transaction is in flight
// timing:
//   the state updates at the edge that takes the command; its result is
//   valid in the next cycle
//   one command per cycle while res is taken, set by the state update
//   feeding the output register
// reset:
//   both drives at 1500 us, no auto-feed, no pending stop, registers at
//   50 and 30 ticks; res channel empty
// stall:
//   while res is held, the output register keeps its transaction and
//   cmd.ready drops until the result is taken
// ----------------------------------------------------------------------------
module feeder_sequencer_with_ramped_drives
    import fsc_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    fsc_cmd_if.sink          cmd,
    fsc_res_if.source        res,
    input  wire              cfg_we,
    input  wire              cfg_index,
    input  wire [CFG_W-1:0]  cfg_data
);

    // configuration
    count_t max_shoot_reg;
    count_t spin_down_reg;

    // drive and sequence state
    pulse_t fly_goal_reg,  fly_goal_next;
    pulse_t fly_now_reg,   fly_now_next;
    pulse_t feed_goal_reg, feed_goal_next;
    pulse_t feed_now_reg,  feed_now_next;
    logic   stop_pend_reg, stop_pend_next;
    count_t stop_cnt_reg,  stop_cnt_next;
    logic   feeding_reg,   feeding_next;
    count_t elapsed_reg,   elapsed_next;
    logic   ir_prev_reg,   ir_prev_next;
    logic   seen_rise_reg, seen_rise_next;

    // output register
    logic       res_valid_reg;
    pulse_t     res_fly_reg;
    pulse_t     res_feed_reg;
    feed_stat_t res_stat_reg, res_stat_next;
    logic       res_auto_reg;

    logic   take;
    op_t    op;
    pulse_t fly_ramped;
    pulse_t feed_ramped;
    pulse_t fly_goal_tick;
    logic   end_feed;

    assign cmd.ready = !res_valid_reg || res.ready;
    assign take      = cmd.valid && cmd.ready;
    assign op        = op_t'(cmd.op);

    assign res.valid             = res_valid_reg;
    assign res.flywheel_pulse_us = res_fly_reg;
    assign res.feeder_pulse_us   = res_feed_reg;
    assign res.feeder_status     = res_stat_reg;
    assign res.auto_feeding      = res_auto_reg;

    fsc_ramp u_fly_ramp
    (
        .now  (fly_now_reg),
        .goal (fly_goal_tick),
        .next (fly_ramped)
    );

    fsc_ramp u_feed_ramp
    (
        .now  (feed_now_reg),
        .goal (feed_goal_reg),
        .next (feed_ramped)
    );

    // deferred flywheel stop, checked ahead of the ramp
    always_comb
    begin
        fly_goal_tick = fly_goal_reg;
        if (stop_pend_reg && (stop_cnt_reg <= count_t'(1)))
        begin
            fly_goal_tick = PULSE_MID;
        end
    end

    always_comb
    begin
        fly_goal_next  = fly_goal_reg;
        fly_now_next   = fly_now_reg;
        feed_goal_next = feed_goal_reg;
        feed_now_next  = feed_now_reg;
        stop_pend_next = stop_pend_reg;
        stop_cnt_next  = stop_cnt_reg;
        feeding_next   = feeding_reg;
        elapsed_next   = elapsed_reg;
        ir_prev_next   = ir_prev_reg;
        seen_rise_next = seen_rise_reg;
        end_feed       = 1'b0;

        unique case (op)
            OP_TICK:
            begin
                if (stop_pend_reg)
                begin
                    if (stop_cnt_reg != '0)
                    begin
                        stop_cnt_next = stop_cnt_reg - count_t'(1);
                    end
                    if (stop_cnt_reg <= count_t'(1))
                    begin
                        stop_pend_next = 1'b0;
                    end
                end
                fly_goal_next = fly_goal_tick;
                fly_now_next  = fly_ramped;
                feed_now_next = feed_ramped;

                if (feeding_reg)
                begin
                    if (elapsed_reg != CNT_MAX)
                    begin
                        elapsed_next = elapsed_reg + count_t'(1);
                    end
                    if (elapsed_next > max_shoot_reg)
                    begin
                        end_feed = 1'b1;
                    end
                    else
                    begin
                        if (cmd.ir_level != ir_prev_reg)
                        begin
                            if (cmd.ir_level)
                            begin
                                seen_rise_next = 1'b1;
                            end
                            if (!seen_rise_next || cmd.ir_level)
                            begin
                                feed_goal_next = PULSE_HIGH;
                            end
                            else
                            begin
                                end_feed = 1'b1;
                            end
                        end
                        ir_prev_next = cmd.ir_level;
                    end
                end

                if (end_feed)
                begin
                    feeding_next   = 1'b0;
                    feed_goal_next = PULSE_MID;
                    stop_pend_next = 1'b1;
                    stop_cnt_next  = spin_down_reg;
                end
            end
            OP_FLY_ON:
            begin
                stop_pend_next = 1'b0;
                fly_goal_next  = PULSE_HIGH;
            end
            OP_FLY_OFF:
            begin
                stop_pend_next = 1'b0;
                fly_goal_next  = PULSE_MID;
            end
            OP_FEED_ON:
            begin
                feed_goal_next = PULSE_HIGH;
            end
            OP_FEED_OFF:
            begin
                feed_goal_next = PULSE_MID;
            end
            OP_FEED_REV:
            begin
                feed_goal_next = PULSE_LOW;
            end
            OP_AUTO_FEED:
            begin
                feeding_next   = 1'b1;
                seen_rise_next = 1'b0;
                ir_prev_next   = 1'b1;
                elapsed_next   = '0;
                stop_pend_next = 1'b0;
                fly_goal_next  = PULSE_HIGH;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (feed_now_next == PULSE_MID)
        begin
            res_stat_next = FEED_STAT_OFF;
        end
        else if (feed_now_next == PULSE_HIGH)
        begin
            res_stat_next = FEED_STAT_FULL;
        end
        else
        begin
            res_stat_next = FEED_STAT_OTHER;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_shoot_reg <= count_t'(50);
            spin_down_reg <= count_t'(30);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAX_SHOOT: max_shoot_reg <= cfg_data;
                CFG_SPIN_DOWN: spin_down_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fly_goal_reg  <= PULSE_MID;
            fly_now_reg   <= PULSE_MID;
            feed_goal_reg <= PULSE_MID;
            feed_now_reg  <= PULSE_MID;
            stop_pend_reg <= 1'b0;
            stop_cnt_reg  <= '0;
            feeding_reg   <= 1'b0;
            elapsed_reg   <= '0;
            ir_prev_reg   <= 1'b0;
            seen_rise_reg <= 1'b0;
        end
        else if (take)
        begin
            fly_goal_reg  <= fly_goal_next;
            fly_now_reg   <= fly_now_next;
            feed_goal_reg <= feed_goal_next;
            feed_now_reg  <= feed_now_next;
            stop_pend_reg <= stop_pend_next;
            stop_cnt_reg  <= stop_cnt_next;
            feeding_reg   <= feeding_next;
            elapsed_reg   <= elapsed_next;
            ir_prev_reg   <= ir_prev_next;
            seen_rise_reg <= seen_rise_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_fly_reg  <= fly_now_next;
            res_feed_reg <= feed_now_next;
            res_stat_reg <= res_stat_next;
            res_auto_reg <= feeding_next;
        end
    end

endmodule

`default_nettype wire
